// ----- rtl/core/cdcc_pkg.sv -----
package cdcc_pkg;

  localparam int unsigned DefBaseYear = 2000;
  localparam int unsigned CenturyBase = 2000;

  localparam int unsigned YearW  = 12;
  localparam int unsigned CountW = 16;
  localparam int unsigned AccW   = 17;
  localparam int unsigned MonW   = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned YicW   = 7;
  localparam int unsigned YlenW  = 9;
  localparam int unsigned UpcW   = 4;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_ACC_YEAR,
    UOP_ACC_MONTH,
    UOP_DATE_OUT,
    UOP_ERR_OUT,
    UOP_SET_DOY,
    UOP_SUB_MONTH,
    UOP_CNT_OUT
  } uop_e;

  typedef enum logic [2:0] {
    UC_ALWAYS,
    UC_REQ_CNT,
    UC_BAD_IN,
    UC_YEAR_LT,
    UC_MON_LT,
    UC_YEAR_FITS,
    UC_MON_FITS
  } ucond_e;

  typedef struct packed {
    uop_e              op;
    ucond_e            cond;
    logic [UpcW-1:0]   target;
  } uword_t;

  localparam logic [UpcW-1:0] UaDispatch  = 4'd0;
  localparam logic [UpcW-1:0] UaCheck     = 4'd1;
  localparam logic [UpcW-1:0] UaDateYear  = 4'd2;
  localparam logic [UpcW-1:0] UaDateMonth = 4'd3;
  localparam logic [UpcW-1:0] UaDateOut   = 4'd4;
  localparam logic [UpcW-1:0] UaErrOut    = 4'd5;
  localparam logic [UpcW-1:0] UaCntYear   = 4'd6;
  localparam logic [UpcW-1:0] UaCntDoy    = 4'd7;
  localparam logic [UpcW-1:0] UaCntMonth  = 4'd8;
  localparam logic [UpcW-1:0] UaCntOut    = 4'd9;
  localparam logic [UpcW-1:0] UaLast      = UaCntOut;

  // microcode: when cond holds, run op and jump to target, else step on
  function automatic uword_t urom(input logic [UpcW-1:0] addr);
    uword_t w;
    unique case (addr)
      UaDispatch:  w = '{UOP_NOP,       UC_REQ_CNT,   UaCntYear};
      UaCheck:     w = '{UOP_NOP,       UC_BAD_IN,    UaErrOut};
      UaDateYear:  w = '{UOP_ACC_YEAR,  UC_YEAR_LT,   UaDateYear};
      UaDateMonth: w = '{UOP_ACC_MONTH, UC_MON_LT,    UaDateMonth};
      UaDateOut:   w = '{UOP_DATE_OUT,  UC_ALWAYS,    UaDispatch};
      UaErrOut:    w = '{UOP_ERR_OUT,   UC_ALWAYS,    UaDispatch};
      UaCntYear:   w = '{UOP_ACC_YEAR,  UC_YEAR_FITS, UaCntYear};
      UaCntDoy:    w = '{UOP_SET_DOY,   UC_ALWAYS,    UaCntMonth};
      UaCntMonth:  w = '{UOP_SUB_MONTH, UC_MON_FITS,  UaCntMonth};
      UaCntOut:    w = '{UOP_CNT_OUT,   UC_ALWAYS,    UaDispatch};
      default:     w = '{UOP_NOP,       UC_ALWAYS,    UaDispatch};
    endcase
    return w;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic lp);
    logic [DayW-1:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = lp ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [YlenW-1:0] year_len(input logic lp);
    return lp ? 9'd366 : 9'd365;
  endfunction

endpackage

// ----- rtl/core/cdcc_if.sv -----
interface cdcc_req_if import cdcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [YicW-1:0]   year_in_century;
  logic [MonW-1:0]   month_in;
  logic [DayW-1:0]   day_in;
  logic [CountW-1:0] day_count_in;

  modport source (
    output valid, req_type, year_in_century, month_in, day_in, day_count_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, year_in_century, month_in, day_in, day_count_in,
    output ready
  );
endinterface

interface cdcc_rsp_if import cdcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] day_count_out;
  logic [YearW-1:0]  full_year;
  logic [MonW-1:0]   month_out;
  logic [DayW-1:0]   day_out;
  logic              input_error;

  modport source (
    output valid, day_count_out, full_year, month_out, day_out, input_error,
    input  ready
  );
  modport sink (
    input  valid, day_count_out, full_year, month_out, day_out, input_error,
    output ready
  );
endinterface

// ----- rtl/core/calendar_day_count_converter.sv -----
// date to count: the microcode checks the month and day, then walks the years from the base
//   to the given year and the months before the given one; count to date it walks the whole
//   years in the count (up to 179), sets the day of year, then walks the months; month 0 or > 12 or day 0 is an error
// the microcode walks one year or month a cycle; the output step stalls while a result waits
// the next word can be taken in the same cycle that the result is in the output register
// reset clears the sequencer and the output valid; no clearing pass
module calendar_day_count_converter import cdcc_pkg::*; #(
  parameter int unsigned BaseYear = DefBaseYear
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdcc_req_if.sink   in_i,
  cdcc_rsp_if.source out_o
);

  localparam logic [YearW-1:0] YearInit = YearW'(BaseYear);
  localparam logic [6:0]       C100Init = 7'(BaseYear % 100);
  localparam logic [1:0]       Q4Init   = 2'((BaseYear / 100) % 4);

  logic              busy_q, busy_d;
  logic [UpcW-1:0]   upc_q, upc_d;
  logic              out_valid_q, out_valid_d;

  logic              req_q, req_d;
  logic [YearW-1:0]  tgt_q, tgt_d;
  logic [MonW-1:0]   mon_q, mon_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [6:0]        c100_q, c100_d;
  logic [1:0]        q4_q, q4_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [MonW-1:0]   m_q, m_d;
  logic              lp_q, lp_d;

  logic [CountW-1:0] o_cnt_q, o_cnt_d;
  logic [YearW-1:0]  o_year_q, o_year_d;
  logic [MonW-1:0]   o_mon_q, o_mon_d;
  logic [DayW-1:0]   o_day_q, o_day_d;
  logic              o_err_q, o_err_d;

  uword_t            uw;
  logic              cond_ok;
  logic              is_out;
  logic              out_free;
  logic              ylp;
  logic [YlenW-1:0]  ylen;
  logic [DayW-1:0]   mlen;
  logic [AccW-1:0]   acc_ylen;
  logic [AccW-1:0]   date_sum;

  assign uw       = urom(upc_q);
  assign ylp      = (year_q[1:0] == 2'd0) && ((c100_q != 7'd0) || (q4_q == 2'd0));
  assign ylen     = year_len(ylp);
  assign mlen     = month_len(m_q, lp_q);
  assign acc_ylen = acc_q + AccW'(ylen);
  assign date_sum = acc_q + AccW'(day_q) - AccW'(1);
  assign out_free = !out_valid_q || out_o.ready;
  assign is_out   = (uw.op == UOP_DATE_OUT) || (uw.op == UOP_ERR_OUT) ||
                    (uw.op == UOP_CNT_OUT);

  assign in_i.ready          = !busy_q;
  assign out_o.valid         = out_valid_q;
  assign out_o.day_count_out = o_cnt_q;
  assign out_o.full_year     = o_year_q;
  assign out_o.month_out     = o_mon_q;
  assign out_o.day_out       = o_day_q;
  assign out_o.input_error   = o_err_q;

  always_comb begin
    unique case (uw.cond)
      UC_ALWAYS:    cond_ok = 1'b1;
      UC_REQ_CNT:   cond_ok = req_q;
      UC_BAD_IN:    cond_ok = (mon_q == 4'd0) || (mon_q > 4'd12) || (day_q == 5'd0);
      UC_YEAR_LT:   cond_ok = year_q < tgt_q;
      UC_MON_LT:    cond_ok = m_q < mon_q;
      UC_YEAR_FITS: cond_ok = acc_ylen <= AccW'(cnt_q);
      UC_MON_FITS:  cond_ok = (m_q < 4'd12) && (acc_q >= AccW'(mlen));
      default:      cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    upc_d       = upc_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    tgt_d       = tgt_q;
    mon_d       = mon_q;
    day_d       = day_q;
    cnt_d       = cnt_q;
    year_d      = year_q;
    c100_d      = c100_q;
    q4_d        = q4_q;
    acc_d       = acc_q;
    m_d         = m_q;
    lp_d        = lp_q;
    o_cnt_d     = o_cnt_q;
    o_year_d    = o_year_q;
    o_mon_d     = o_mon_q;
    o_day_d     = o_day_q;
    o_err_d     = o_err_q;

    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (in_i.valid && in_i.ready) begin
      busy_d = 1'b1;
      upc_d  = UaDispatch;
      req_d  = in_i.req_type;
      tgt_d  = YearW'(CenturyBase) + YearW'(in_i.year_in_century);
      mon_d  = in_i.month_in;
      day_d  = in_i.day_in;
      cnt_d  = in_i.day_count_in;
      year_d = YearInit;
      c100_d = C100Init;
      q4_d   = Q4Init;
      acc_d  = '0;
      m_d    = 4'd1;
      // 2100 is the only century year in range that is not leap
      lp_d   = (in_i.year_in_century[1:0] == 2'd0) && (in_i.year_in_century != 7'd100);
    end else if (busy_q && !(is_out && !out_free)) begin
      if (cond_ok) begin
        upc_d = uw.target;
        unique case (uw.op)
          UOP_NOP: begin
          end
          UOP_ACC_YEAR: begin
            acc_d  = acc_ylen;
            year_d = year_q + YearW'(1);
            if (c100_q == 7'd99) begin
              c100_d = '0;
              q4_d   = q4_q + 2'd1;
            end else begin
              c100_d = c100_q + 7'd1;
            end
          end
          UOP_ACC_MONTH: begin
            acc_d = acc_q + AccW'(mlen);
            m_d   = m_q + 4'd1;
          end
          UOP_SET_DOY: begin
            acc_d = AccW'(cnt_q) - acc_q;
            lp_d  = ylp;
          end
          UOP_SUB_MONTH: begin
            acc_d = acc_q - AccW'(mlen);
            m_d   = m_q + 4'd1;
          end
          UOP_DATE_OUT: begin
            busy_d      = 1'b0;
            out_valid_d = 1'b1;
            o_cnt_d     = date_sum[AccW-1] ? '1 : date_sum[CountW-1:0];
            o_year_d    = '0;
            o_mon_d     = '0;
            o_day_d     = '0;
            o_err_d     = 1'b0;
          end
          UOP_ERR_OUT: begin
            busy_d      = 1'b0;
            out_valid_d = 1'b1;
            o_cnt_d     = '0;
            o_year_d    = '0;
            o_mon_d     = '0;
            o_day_d     = '0;
            o_err_d     = 1'b1;
          end
          UOP_CNT_OUT: begin
            busy_d      = 1'b0;
            out_valid_d = 1'b1;
            o_cnt_d     = '0;
            o_year_d    = year_q;
            o_mon_d     = m_q;
            o_day_d     = acc_q[DayW-1:0] + 5'd1;
            o_err_d     = 1'b0;
          end
          default: begin
          end
        endcase
      end else begin
        upc_d = upc_q + UpcW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= UaDispatch;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    tgt_q    <= tgt_d;
    mon_q    <= mon_d;
    day_q    <= day_d;
    cnt_q    <= cnt_d;
    year_q   <= year_d;
    c100_q   <= c100_d;
    q4_q     <= q4_d;
    acc_q    <= acc_d;
    m_q      <= m_d;
    lp_q     <= lp_d;
    o_cnt_q  <= o_cnt_d;
    o_year_q <= o_year_d;
    o_mon_q  <= o_mon_d;
    o_day_q  <= o_day_d;
    o_err_q  <= o_err_d;
  end

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> upc_q <= UaLast)
    else $error("step counter out of program");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> busy_q && upc_q == UaDispatch)
    else $error("accepted word did not start the program");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_err_q) |-> (o_cnt_q == '0 && o_year_q == '0 && o_mon_q == '0))
    else $error("error result carries data");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> !busy_q)
    else $error("result issued while still busy");

endmodule
